// File: rtl/assert_macros.svh
// Assertion macros shared by the dedup table RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// cond must hold on every cycle out of reset
`define VTDT_ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("vtdt: invariant violated");
// same-cycle implication
`define VTDT_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("vtdt: implication violated");
// next-cycle implication
`define VTDT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("vtdt: next-cycle implication violated");
`else
`define VTDT_ASSERT_ALWAYS(lbl, clk, rst, cond)
`define VTDT_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define VTDT_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// File: rtl/vtdt_pkg.sv
// Types and constants for the vertex triple dedup table.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package vtdt_pkg;

   // result field layout
   localparam int VERTEX_W = 11;
   localparam int RSP_DW   = 16;

   // request kinds carried on req_tuser
   localparam logic MODE_LOOKUP = 1'b0;
   localparam logic MODE_CLEAR  = 1'b1;

   // result status codes
   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   // hash multipliers
   localparam logic [63:0] MUL_POS = 64'h9E3779B97F4A7C15;
   localparam logic [63:0] MUL_UV  = 64'hC2B2AE3D27D4EB4F;
   localparam logic [63:0] MUL_NRM = 64'h165667B19E3779F9;
   localparam logic [63:0] MUL_FIN = 64'hD6E8FEB86659FD93;

   // hash sequencer steps; each multiply step names the multiply issued in that cycle
   typedef enum logic [3:0] {
      HS_P_LO,
      HS_P_HI,
      HS_T_LO,
      HS_T_HI,
      HS_N_LO,
      HS_N_HI,
      HS_N_ADD,
      HS_FOLD,
      HS_F_LL,
      HS_F_LH,
      HS_F_HL,
      HS_FINAL
   } hstep_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HASH,
      ST_SLOT_CHK,
      ST_KEY_CHK,
      ST_DONE
   } vtdt_state_type;

   typedef struct packed {
      logic slot_rd;
      logic slot_wr;
      logic key_rd;
      logic key_wr;
   } store_ctl_type;

endpackage

// File: rtl/vtdt_hash.sv
// Iterative triple hash: one shared 32x32 multiplier under a 12-step sequencer.
// Depends on vtdt_pkg (multiplier constants, step enum).
`timescale 1ns / 1ps

module vtdt_hash import vtdt_pkg::*; #(
   parameter int INDEX_WIDTH = 24,
   parameter int SLOT_AW     = 12
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [INDEX_WIDTH-1:0] pos,
   input  logic [INDEX_WIDTH-1:0] uv,
   input  logic [INDEX_WIDTH-1:0] nrm,
   output logic                   done,
   output logic [SLOT_AW-1:0]     slot
);

   logic            busy_ff, busy_in;
   hstep_type       step_ff, step_in;
   logic [31:0]     p_ff, t_ff, n_ff;
   logic [31:0]     p_in, t_in, n_in;
   logic [63:0]     prod_ff, prod_in;
   logic [63:0]     term_ff, term_in;
   logic [63:0]     h_ff, h_in;
   logic [31:0]     mul_a, mul_b;
   logic [31:0]     fin_hi;
   logic [63:0]     h_mix;

   // full 64-bit product mod 2^64: low product plus low half of high product, shifted
   assign h_mix  = h_ff ^ {term_ff[63:32] + prod_ff[31:0], term_ff[31:0]};
   assign fin_hi = term_ff[63:32] + prod_ff[31:0];
   assign done   = busy_ff && (step_ff == HS_FINAL);
   assign slot   = SLOT_AW'(term_ff[31:0] ^ fin_hi);

   // next step
   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      if (!busy_ff) begin
         if (start) begin
            busy_in = 1'b1;
            step_in = HS_P_LO;
         end
      end else begin
         case (step_ff)
            HS_P_LO:  step_in = HS_P_HI;
            HS_P_HI:  step_in = HS_T_LO;
            HS_T_LO:  step_in = HS_T_HI;
            HS_T_HI:  step_in = HS_N_LO;
            HS_N_LO:  step_in = HS_N_HI;
            HS_N_HI:  step_in = HS_N_ADD;
            HS_N_ADD: step_in = HS_FOLD;
            HS_FOLD:  step_in = HS_F_LL;
            HS_F_LL:  step_in = HS_F_LH;
            HS_F_LH:  step_in = HS_F_HL;
            HS_F_HL:  step_in = HS_FINAL;
            HS_FINAL: begin
               step_in = HS_P_LO;
               busy_in = 1'b0;
            end
            default:  step_in = HS_P_LO;
         endcase
      end
   end

   // multiplier operands and accumulation
   always_comb begin
      mul_a   = '0;
      mul_b   = '0;
      p_in    = p_ff;
      t_in    = t_ff;
      n_in    = n_ff;
      term_in = term_ff;
      h_in    = h_ff;
      case (step_ff)
         HS_P_LO: begin
            mul_a = p_ff;
            mul_b = MUL_POS[31:0];
         end
         HS_P_HI: begin
            mul_a = p_ff;
            mul_b = MUL_POS[63:32];
         end
         HS_T_LO: begin
            mul_a = t_ff;
            mul_b = MUL_UV[31:0];
         end
         HS_T_HI: begin
            mul_a = t_ff;
            mul_b = MUL_UV[63:32];
         end
         HS_N_LO: begin
            mul_a = n_ff;
            mul_b = MUL_NRM[31:0];
         end
         HS_N_HI: begin
            mul_a = n_ff;
            mul_b = MUL_NRM[63:32];
         end
         HS_F_LL: begin
            mul_a = h_ff[31:0];
            mul_b = MUL_FIN[31:0];
         end
         HS_F_LH: begin
            mul_a = h_ff[31:0];
            mul_b = MUL_FIN[63:32];
         end
         HS_F_HL: begin
            mul_a = h_ff[63:32];
            mul_b = MUL_FIN[31:0];
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase

      if (!busy_ff) begin
         if (start) begin
            p_in = 32'(pos);
            t_in = 32'(uv);
            n_in = 32'(nrm);
            h_in = '0;
         end
      end else begin
         case (step_ff)
            HS_P_HI, HS_T_HI, HS_N_HI, HS_F_LH: term_in = prod_ff;
            HS_T_LO, HS_N_LO, HS_N_ADD:        h_in    = h_mix;
            HS_FOLD:  h_in = {h_ff[63:32], h_ff[31:0] ^ h_ff[63:32]};
            HS_F_HL:  term_in = {fin_hi, term_ff[31:0]};
            default:  h_in = h_ff;
         endcase
      end
   end

   assign prod_in = 64'(mul_a) * 64'(mul_b);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= HS_P_LO;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      p_ff    <= p_in;
      t_ff    <= t_in;
      n_ff    <= n_in;
      prod_ff <= prod_in;
      term_ff <= term_in;
      h_ff    <= h_h_sel(h_in);
   end

   function automatic logic [63:0] h_h_sel(input logic [63:0] v);
      h_h_sel = v;
   endfunction

endmodule

// File: rtl/vtdt_store.sv
// Slot table and key store memories of the dedup table, registered reads.
// Depends on vtdt_pkg (store_ctl_type).
`timescale 1ns / 1ps

module vtdt_store import vtdt_pkg::*; #(
   parameter int SLOT_COUNT  = 4096,
   parameter int INDEX_WIDTH = 24
) (
   input  logic                               clock,
   input  store_ctl_type                      ctl,
   input  logic [$clog2(SLOT_COUNT)-1:0]      slot_rd_addr,
   input  logic [$clog2(SLOT_COUNT)-1:0]      slot_wr_addr,
   input  logic [$clog2(SLOT_COUNT/2):0]      slot_wr_data,
   output logic [$clog2(SLOT_COUNT/2):0]      slot_rd_data,
   input  logic [$clog2(SLOT_COUNT/2)-1:0]    key_rd_addr,
   input  logic [$clog2(SLOT_COUNT/2)-1:0]    key_wr_addr,
   input  logic [3*INDEX_WIDTH-1:0]           key_wr_data,
   output logic [3*INDEX_WIDTH-1:0]           key_rd_data
);

   localparam int KEY_DEPTH = SLOT_COUNT / 2;
   localparam int SLOT_EW   = $clog2(KEY_DEPTH) + 1;
   localparam int KEY_W     = 3 * INDEX_WIDTH;

   // slot entry holds vertex+1, zero = empty
   logic [SLOT_EW-1:0] slot_mem [SLOT_COUNT];
   // {normal, uv, position} per vertex
   logic [KEY_W-1:0]   key_mem  [KEY_DEPTH];

   always_ff @(posedge clock) begin
      if (ctl.slot_wr) begin
         slot_mem[slot_wr_addr] <= slot_wr_data;
      end
      if (ctl.slot_rd) begin
         slot_rd_data <= slot_mem[slot_rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.key_wr) begin
         key_mem[key_wr_addr] <= key_wr_data;
      end
      if (ctl.key_rd) begin
         key_rd_data <= key_mem[key_rd_addr];
      end
   end

endmodule

// File: rtl/vertex_triple_dedup_table.sv
// Top level of the vertex triple dedup table: request/response channels,
// probe sequencer and result register. Depends on vtdt_pkg, vtdt_hash,
// vtdt_store and assert_macros.svh.
//
// Usage:
//   req_* takes one corner per beat: tuser selects lookup/insert (0) or clear
//   (1); tdata carries the position, uv and normal indices. rsp_* returns one
//   beat per request: the vertex number in tdata, is_new and full in tuser.
//   Lookup: hashing on the shared multiplier, then a slot read per probe plus
//   a key compare on an occupied slot, then the result register; an empty
//   slot ends the probe with an insert or a full status, a matching key ends
//   it with a hit, and each occupied slot passed over adds one more probe.
//   Clear: one slot written per cycle over the whole table, then the result.
//   One request is in flight at a time; req_tready is high only when idle, so
//   a new corner is taken only once the last one has reached its result.
//   Reset: synchronous; after it the whole slot table is swept to empty with
//   req_tready low. Key store contents are not reset.
//   Stall: a result held by a low rsp_tready keeps its beat; the next request
//   may be accepted and hashed meanwhile, and waits before its own result.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module vertex_triple_dedup_table import vtdt_pkg::*; #(
   parameter int SLOT_COUNT  = 4096,
   parameter int INDEX_WIDTH = 24
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // position_index, uv_index, normal_index, zero pad
   input  logic [((3*INDEX_WIDTH+7)/8)*8-1:0]     req_tdata,
   // mode
   input  logic                                   req_tuser,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // vertex, zero pad
   output logic [RSP_DW-1:0]                      rsp_tdata,
   // is_new, status
   output logic [1:0]                             rsp_tuser
);

   localparam int KEY_DEPTH = SLOT_COUNT / 2;
   localparam int SLOT_AW   = $clog2(SLOT_COUNT);
   localparam int KEY_AW    = $clog2(KEY_DEPTH);
   localparam int CNT_W     = KEY_AW + 1;
   localparam int KEY_W     = 3 * INDEX_WIDTH;

   vtdt_state_type           state_ff, state_in;
   logic [SLOT_AW-1:0]       clr_idx_ff, clr_idx_in;
   logic                     clr_req_ff, clr_req_in;
   logic [INDEX_WIDTH-1:0]   pos_ff, uv_ff, nrm_ff;
   logic [INDEX_WIDTH-1:0]   pos_in, uv_in, nrm_in;
   logic [SLOT_AW-1:0]       slot_ff, slot_in;
   logic [KEY_AW-1:0]        vi_ff, vi_in;
   logic [CNT_W-1:0]         vcount_ff, vcount_in;
   logic [KEY_AW-1:0]        res_vertex_ff, res_vertex_in;
   logic                     res_new_ff, res_new_in;
   logic                     res_status_ff, res_status_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [VERTEX_W-1:0]      rsp_vertex_ff, rsp_vertex_in;
   logic                     rsp_new_ff, rsp_new_in;
   logic                     rsp_status_ff, rsp_status_in;

   logic [INDEX_WIDTH-1:0]   req_pos, req_uv, req_nrm;
   logic                     req_fire;
   logic                     rsp_free;
   logic                     hash_start;
   logic                     hash_done;
   logic [SLOT_AW-1:0]       hash_slot;
   store_ctl_type            ctl;
   logic [SLOT_AW-1:0]       slot_rd_addr, slot_wr_addr;
   logic [CNT_W-1:0]         slot_wr_data, slot_rd_data;
   logic [KEY_AW-1:0]        key_rd_addr, key_wr_addr;
   logic [KEY_W-1:0]         key_wr_data, key_rd_data;
   logic                     entry_empty;
   logic                     table_full;
   logic                     key_hit;
   logic [KEY_AW-1:0]        entry_vi;

   assign req_pos = req_tdata[INDEX_WIDTH-1:0];
   assign req_uv  = req_tdata[2*INDEX_WIDTH-1:INDEX_WIDTH];
   assign req_nrm = req_tdata[3*INDEX_WIDTH-1:2*INDEX_WIDTH];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   assign entry_empty = (slot_rd_data == '0);
   assign table_full  = (vcount_ff == CNT_W'(KEY_DEPTH));
   assign key_hit     = (key_rd_data == {nrm_ff, uv_ff, pos_ff});
   assign entry_vi    = KEY_AW'(slot_rd_data - 1'b1);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DW'(rsp_vertex_ff);
   assign rsp_tuser  = {rsp_status_ff, rsp_new_ff};

   vtdt_hash #(
      .INDEX_WIDTH (INDEX_WIDTH),
      .SLOT_AW     (SLOT_AW)
   ) u_hash (
      .clock (clock),
      .reset (reset),
      .start (hash_start),
      .pos   (req_pos),
      .uv    (req_uv),
      .nrm   (req_nrm),
      .done  (hash_done),
      .slot  (hash_slot)
   );

   vtdt_store #(
      .SLOT_COUNT  (SLOT_COUNT),
      .INDEX_WIDTH (INDEX_WIDTH)
   ) u_store (
      .clock        (clock),
      .ctl          (ctl),
      .slot_rd_addr (slot_rd_addr),
      .slot_wr_addr (slot_wr_addr),
      .slot_wr_data (slot_wr_data),
      .slot_rd_data (slot_rd_data),
      .key_rd_addr  (key_rd_addr),
      .key_wr_addr  (key_wr_addr),
      .key_wr_data  (key_wr_data),
      .key_rd_data  (key_rd_data)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_idx_ff == SLOT_AW'(SLOT_COUNT - 1)) begin
               state_in = clr_req_ff ? ST_DONE : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               state_in = (req_tuser == MODE_CLEAR) ? ST_CLEAR : ST_HASH;
            end
         end
         ST_HASH: begin
            if (hash_done) begin
               state_in = ST_SLOT_CHK;
            end
         end
         ST_SLOT_CHK: state_in = entry_empty ? ST_DONE : ST_KEY_CHK;
         ST_KEY_CHK:  state_in = key_hit ? ST_DONE : ST_SLOT_CHK;
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      clr_idx_in    = clr_idx_ff;
      clr_req_in    = clr_req_ff;
      pos_in        = pos_ff;
      uv_in         = uv_ff;
      nrm_in        = nrm_ff;
      slot_in       = slot_ff;
      vi_in         = vi_ff;
      vcount_in     = vcount_ff;
      res_vertex_in = res_vertex_ff;
      res_new_in    = res_new_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_vertex_in = rsp_vertex_ff;
      rsp_new_in    = rsp_new_ff;
      rsp_status_in = rsp_status_ff;
      hash_start    = 1'b0;
      ctl           = '0;
      slot_rd_addr  = slot_ff;
      slot_wr_addr  = slot_ff;
      slot_wr_data  = '0;
      key_rd_addr   = entry_vi;
      key_wr_addr   = vcount_ff[KEY_AW-1:0];
      key_wr_data   = {nrm_ff, uv_ff, pos_ff};

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            ctl.slot_wr  = 1'b1;
            slot_wr_addr = clr_idx_ff;
            slot_wr_data = '0;
            clr_idx_in   = clr_idx_ff + 1'b1;
         end
         ST_IDLE: begin
            if (req_fire) begin
               pos_in = req_pos;
               uv_in  = req_uv;
               nrm_in = req_nrm;
               if (req_tuser == MODE_CLEAR) begin
                  clr_req_in    = 1'b1;
                  clr_idx_in    = '0;
                  vcount_in     = '0;
                  res_vertex_in = '0;
                  res_new_in    = 1'b0;
                  res_status_in = STATUS_OK;
               end else begin
                  hash_start = 1'b1;
               end
            end
         end
         ST_HASH: begin
            if (hash_done) begin
               slot_in      = hash_slot;
               ctl.slot_rd  = 1'b1;
               slot_rd_addr = hash_slot;
            end
         end
         ST_SLOT_CHK: begin
            if (entry_empty) begin
               if (table_full) begin
                  res_vertex_in = '0;
                  res_new_in    = 1'b0;
                  res_status_in = STATUS_FULL;
               end else begin
                  ctl.key_wr    = 1'b1;
                  ctl.slot_wr   = 1'b1;
                  slot_wr_data  = vcount_ff + 1'b1;
                  res_vertex_in = vcount_ff[KEY_AW-1:0];
                  res_new_in    = 1'b1;
                  res_status_in = STATUS_OK;
                  vcount_in     = vcount_ff + 1'b1;
               end
            end else begin
               vi_in      = entry_vi;
               ctl.key_rd = 1'b1;
            end
         end
         ST_KEY_CHK: begin
            if (key_hit) begin
               res_vertex_in = vi_ff;
               res_new_in    = 1'b0;
               res_status_in = STATUS_OK;
            end else begin
               // linear probe, wraps at the table end
               slot_in      = slot_ff + 1'b1;
               ctl.slot_rd  = 1'b1;
               slot_rd_addr = slot_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_vertex_in = VERTEX_W'(res_vertex_ff);
               rsp_new_in    = res_new_ff;
               rsp_status_in = res_status_ff;
               clr_req_in    = 1'b0;
            end
         end
         default: begin
            ctl = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_idx_ff   <= '0;
         clr_req_ff   <= 1'b0;
         vcount_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         clr_req_ff   <= clr_req_in;
         vcount_ff    <= vcount_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      uv_ff         <= uv_in;
      nrm_ff        <= nrm_in;
      slot_ff       <= slot_in;
      vi_ff         <= vi_in;
      res_vertex_ff <= res_vertex_in;
      res_new_ff    <= res_new_in;
      res_status_ff <= res_status_in;
      rsp_vertex_ff <= rsp_vertex_in;
      rsp_new_ff    <= rsp_new_in;
      rsp_status_ff <= rsp_status_in;
   end

   `VTDT_ASSERT_ALWAYS(a_vcount_cap, clock, reset, vcount_ff <= CNT_W'(KEY_DEPTH))
   `VTDT_ASSERT_IMPLY(a_new_not_full, clock, reset, rsp_valid_ff, !(rsp_new_ff && rsp_status_ff))
   `VTDT_ASSERT_NEXT(a_insert_count, clock, reset, ctl.key_wr, vcount_ff == $past(vcount_ff) + 1'b1)
   `VTDT_ASSERT_IMPLY(a_key_slot_pair, clock, reset, ctl.key_wr, ctl.slot_wr)
   `VTDT_ASSERT_IMPLY(a_hash_owner, clock, reset, hash_done, state_ff == ST_HASH)

endmodule
